FILE: rtl/avms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// avms_pkg: shared definitions for the aligned value match scanner
// register indexes, default widths and floating-point compare helpers
// ----------------------------------------------------------------------------
package avms_pkg;

    localparam int OFFSET_WIDTH_DEFAULT = 32;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH = 64;
    localparam int MAX_STEP = 64;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SEARCH_VALUE = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SIZE_LOG2 = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ALIGN_STEP = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FLOAT_MODE = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RANGE_LOW = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RANGE_HIGH = 3'd5;

    // a < b as ieee single, nan never compares, -0 == +0
    function automatic logic flt_lt32(input logic [31:0] a, input logic [31:0] b);
        logic a_nan;
        logic b_nan;
        logic both_zero;
        logic res;
        a_nan = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
        b_nan = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
        both_zero = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
        if (a_nan || b_nan || both_zero)
        begin
            res = 1'b0;
        end
        else if (a[31] != b[31])
        begin
            res = a[31];
        end
        else if (!a[31])
        begin
            res = a[30:0] < b[30:0];
        end
        else
        begin
            res = a[30:0] > b[30:0];
        end
        return res;
    endfunction

    function automatic logic flt_lt64(input logic [63:0] a, input logic [63:0] b);
        logic a_nan;
        logic b_nan;
        logic both_zero;
        logic res;
        a_nan = (a[62:52] == 11'h7ff) && (a[51:0] != 52'd0);
        b_nan = (b[62:52] == 11'h7ff) && (b[51:0] != 52'd0);
        both_zero = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
        if (a_nan || b_nan || both_zero)
        begin
            res = 1'b0;
        end
        else if (a[63] != b[63])
        begin
            res = a[63];
        end
        else if (!a[63])
        begin
            res = a[62:0] < b[62:0];
        end
        else
        begin
            res = a[62:0] > b[62:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/aligned_value_match_scanner.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aligned_value_match_scanner
// scans a little-endian byte stream for aligned values matching a pattern
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one byte per transaction (tdata) with tlast on the final
//   byte of an image. m_axis returns results: tdata holds match_offset in
//   bits 31:0 and match_total in bits 63:32, tuser holds is_end.
//   each byte is compared in the cycle it is taken; a result is registered
//   in the output register, or in the skid stage while the receiver stalls.
//   throughput is one byte per cycle while s_axis_tready is high. a final byte
//   that both matches and ends the image gives two results; the second waits
//   in a one-entry skid stage and the input is held off while it waits.
//   a stalled receiver holds the output register; the skid stage absorbs
//   one result (two when a final byte matches, the second in a pending
//   entry behind it), after which s_axis_tready drops.
//   reset clears the window, offset, phase, match count and config registers
//   (value width 4 bytes, step 1).
// ----------------------------------------------------------------------------
module aligned_value_match_scanner
    import avms_pkg::*;
#(
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEFAULT
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [7:0]                 s_axis_tdata,  // data_byte
    input  wire logic                       s_axis_tlast,  // last_byte
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic [63:0]                     m_axis_tdata,  // match_offset, match_total
    output logic                            m_axis_tuser   // is_end
);

    logic [63:0] search_reg;
    logic [1:0]  size_reg;
    logic [6:0]  step_reg;
    logic        float_reg;
    logic [63:0] low_reg;
    logic [63:0] high_reg;

    logic [55:0]             window_reg;
    logic [OFFSET_WIDTH-1:0] seen_reg;
    logic [5:0]              phase_reg;
    logic [31:0]             count_reg;
    logic [2:0]              fill_reg;

    logic        out_valid_reg;
    logic [64:0] out_data_reg;
    logic        skid_valid_reg;
    logic [64:0] skid_data_reg;
    logic        pend_valid_reg;
    logic [64:0] pend_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_reg <= '0;
            size_reg <= 2'd2;
            step_reg <= 7'd1;
            float_reg <= 1'b0;
            low_reg <= '0;
            high_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SEARCH_VALUE: search_reg <= cfg_data;
                REG_SIZE_LOG2:    size_reg <= cfg_data[1:0];
                REG_ALIGN_STEP:   step_reg <= cfg_data[6:0];
                REG_FLOAT_MODE:   float_reg <= cfg_data[0];
                REG_RANGE_LOW:    low_reg <= cfg_data;
                REG_RANGE_HIGH:   high_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    logic        take;
    logic [63:0] full;
    logic [63:0] val;
    logic [63:0] vmask;
    logic [2:0]  width_m1;
    logic [6:0]  step_eff;
    logic        ready_check;
    logic        hit;
    logic        report;
    logic [5:0]  phase_next;
    logic [31:0] count_next;
    logic [OFFSET_WIDTH-1:0] offset;
    logic        push_match;
    logic        push_end;
    logic [64:0] match_word;
    logic [64:0] end_word;

    assign s_axis_tready = !skid_valid_reg;
    assign take = s_axis_tvalid && s_axis_tready;
    assign full = {s_axis_tdata, window_reg};

    always_comb
    begin
        case (size_reg)
            2'd0:
            begin
                width_m1 = 3'd0;
                val = {56'd0, full[63:56]};
                vmask = 64'h0000_0000_0000_00ff;
            end
            2'd1:
            begin
                width_m1 = 3'd1;
                val = {48'd0, full[63:48]};
                vmask = 64'h0000_0000_0000_ffff;
            end
            2'd2:
            begin
                width_m1 = 3'd3;
                val = {32'd0, full[63:32]};
                vmask = 64'h0000_0000_ffff_ffff;
            end
            default:
            begin
                width_m1 = 3'd7;
                val = full;
                vmask = '1;
            end
        endcase
    end

    always_comb
    begin
        if (step_reg == 7'd0)
        begin
            step_eff = 7'd1;
        end
        else if (step_reg > 7'(MAX_STEP))
        begin
            step_eff = 7'(MAX_STEP);
        end
        else
        begin
            step_eff = step_reg;
        end
    end

    assign ready_check = fill_reg >= width_m1;

    always_comb
    begin
        hit = val == (search_reg & vmask);
        if (float_reg && size_reg == 2'd2 &&
            flt_lt32(low_reg[31:0], val[31:0]) && flt_lt32(val[31:0], high_reg[31:0]))
        begin
            hit = 1'b1;
        end
        if (float_reg && size_reg == 2'd3 &&
            flt_lt64(low_reg, val) && flt_lt64(val, high_reg))
        begin
            hit = 1'b1;
        end
    end

    assign report = ready_check && hit && (phase_reg == 6'd0);
    assign count_next = (report && count_reg != '1) ? count_reg + 32'd1 : count_reg;
    assign offset = seen_reg - OFFSET_WIDTH'(width_m1);

    always_comb
    begin
        if ({1'b0, phase_reg} + 7'd1 >= step_eff)
        begin
            phase_next = 6'd0;
        end
        else
        begin
            phase_next = phase_reg + 6'd1;
        end
    end

    assign push_match = take && report;
    assign push_end = take && s_axis_tlast;
    assign match_word = {1'b0, 32'd0, 32'(offset)};
    assign end_word = {1'b1, count_next, 32'd0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            seen_reg <= '0;
            phase_reg <= '0;
            count_reg <= '0;
            fill_reg <= '0;
        end
        else if (take)
        begin
            if (s_axis_tlast)
            begin
                window_reg <= '0;
                seen_reg <= '0;
                phase_reg <= '0;
                count_reg <= '0;
                fill_reg <= '0;
            end
            else
            begin
                window_reg <= full[63:8];
                seen_reg <= seen_reg + OFFSET_WIDTH'(1);
                if (ready_check)
                begin
                    phase_reg <= phase_next;
                end
                count_reg <= count_next;
                if (fill_reg != 3'd7)
                begin
                    fill_reg <= fill_reg + 3'd1;
                end
            end
        end
    end

    // output register, one skid entry and a pending entry; at most two results per byte
    logic out_free;
    assign out_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (out_free)
                begin
                    out_valid_reg <= 1'b1;
                    // a pending word moves up into the skid entry
                    skid_valid_reg <= pend_valid_reg;
                end
            end
            else if (push_match && push_end)
            begin
                if (out_free)
                begin
                    out_valid_reg <= 1'b1;
                end
                skid_valid_reg <= 1'b1;
            end
            else if (push_match || push_end)
            begin
                if (out_free)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (out_free)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // note: two pushes with the output stalled needs two slots; the input is
    // only taken when the skid is empty, so the match goes to the skid and
    // the end word is held back by the pending flag below
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_free)
            begin
                out_data_reg <= skid_data_reg;
                if (pend_valid_reg)
                begin
                    skid_data_reg <= pend_data_reg;
                end
            end
        end
        else if (push_match && push_end)
        begin
            if (out_free)
            begin
                out_data_reg <= match_word;
                skid_data_reg <= end_word;
            end
            else
            begin
                skid_data_reg <= match_word;
                pend_data_reg <= end_word;
            end
        end
        else if (push_match || push_end)
        begin
            if (out_free)
            begin
                out_data_reg <= push_end ? end_word : match_word;
            end
            else
            begin
                skid_data_reg <= push_end ? end_word : match_word;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg && out_free && pend_valid_reg)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (!skid_valid_reg && push_match && push_end && !out_free)
        begin
            pend_valid_reg <= 1'b1;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg[63:0];
    assign m_axis_tuser = out_data_reg[64];

endmodule

`default_nettype wire

FILE: rtl/avms_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// avms_checker: port-level checks for the aligned value match scanner
// ----------------------------------------------------------------------------
module avms_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        s_axis_tlast,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata,
    input wire logic        m_axis_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_end_offset: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[31:0] == 32'd0)
        else $error("summary with nonzero offset");

    a_match_total: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[63:32] == 32'd0)
        else $error("match result with nonzero total");

    a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast && m_axis_tready
        |=> m_axis_tvalid)
        else $error("no result after final byte");

endmodule

bind aligned_value_match_scanner avms_checker u_avms_checker (
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);

`default_nettype wire
